// ----- src/zlema_pkg.sv -----
package zlema_pkg;

    localparam int PERIOD_W = 8;
    localparam int ALPHA_W  = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd3;
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd32768;

    typedef enum logic [0:0] {
        REG_PERIOD = 1'b0,
        REG_ALPHA  = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_SEED,
        KIND_UPDATE
    } t_kind;

endpackage

// ----- src/zlema_in_if.sv -----
interface zlema_in_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_of_series;

    modport source (output valid, output sample, output start_of_series, input ready);
    modport sink   (input valid, input sample, input start_of_series, output ready);
endinterface

// ----- src/zlema_out_if.sv -----
interface zlema_out_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          saturated;

    modport source (output valid, output average, output saturated, input ready);
    modport sink   (input valid, input average, input saturated, output ready);
endinterface

// ----- src/zlema_ram.sv -----
module zlema_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/zero_lag_ema_filter_top.sv -----
// Zero-lag EMA filter on signed samples; returns at most one average per sample,
// via the stage-one register into a held output register. Stage one writes the
// sample into the delay-line RAM and reads the sample lag positions back; stage
// two applies avg += alpha*((2c-l)-avg) to the running average register, so the
// feedback loop holds only that register and the sustained rate is one sample per
// clock unless the output stalls. The first lag-1 samples of a series give no
// result; sample lag-1 seeds the average. Write period and alpha only while idle.
module zero_lag_ema_filter_top #(
    parameter int MAX_LAG         = 64,
    parameter int SAMPLE_BITS     = 32,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    zlema_in_if.sink                      i_in,
    zlema_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zlema_pkg::APB_AW-1:0]  paddr,
    input  logic [zlema_pkg::APB_DW-1:0]  pwdata,
    output logic [zlema_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    localparam int S    = SAMPLE_BITS;
    localparam int F    = ALPHA_FRAC_BITS;
    localparam int AW   = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int LGW  = $clog2(MAX_LAG + 1);
    localparam int AVW  = S + 2 + F;
    localparam int DW   = AVW + 1;
    localparam int DLW  = (DW + 1) / 2;
    localparam int DHW  = DW - DLW;
    localparam int PLW  = DLW + F;
    localparam int PHW  = DHW + F + 1;
    localparam int PW   = DW + F;
    localparam int AXW  = (F > zlema_pkg::ALPHA_W) ? F + 1 : zlema_pkg::ALPHA_W + 1;

    logic [zlema_pkg::PERIOD_W-1:0] r_period;
    logic [zlema_pkg::ALPHA_W-1:0]  r_alpha;
    logic [AW-1:0]                  r_wp;
    logic [LGW-1:0]                 r_warm;
    logic signed [AVW-1:0]          r_avg;
    logic                           r_s1_vld;
    zlema_pkg::t_kind               r_s1_kind;
    logic signed [S-1:0]            r_s1_c;
    logic                           r_out_vld;
    logic signed [S-1:0]            r_out_avg;
    logic                           r_out_sat;

    logic [AW-1:0]                  n_wp;
    logic [LGW-1:0]                 n_warm;
    logic signed [AVW-1:0]          n_avg;
    zlema_pkg::t_kind               n_kind;
    logic signed [S-1:0]            n_out_avg;
    logic                           n_out_sat;

    logic                           cfg_wr;
    logic                           acc;
    logic                           out_free;
    logic                           s1_go;
    logic [zlema_pkg::PERIOD_W-1:0] lag8;
    logic [LGW-1:0]                 lag;
    logic [LGW-1:0]                 pos;
    logic [LGW:0]                   pos_inc;
    logic [AW+1:0]                  rsum;
    logic [AW-1:0]                  ridx;
    logic [AW:0]                    wp_inc;
    logic [S-1:0]                   rdata;

    logic [AXW-1:0]                 alpha_x;
    logic [AXW-1:0]                 one_x;
    logic [F-1:0]                   a;
    logic signed [S+1:0]            tgt;
    logic signed [DW-1:0]           diff;
    logic [DLW-1:0]                 dl;
    logic signed [DHW-1:0]          dh;
    logic [PLW-1:0]                 pl;
    logic signed [PHW-1:0]          ph;
    logic signed [PW-1:0]           prod;
    logic signed [AVW-1:0]          avg_upd;
    logic signed [S+1:0]            y;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        case (zlema_pkg::t_reg_idx'(paddr[2]))
            zlema_pkg::REG_PERIOD: prdata = zlema_pkg::APB_DW'(r_period);
            zlema_pkg::REG_ALPHA:  prdata = zlema_pkg::APB_DW'(r_alpha);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= zlema_pkg::PERIOD_RST;
            r_alpha  <= zlema_pkg::ALPHA_RST;
        end else if (cfg_wr) begin
            case (zlema_pkg::t_reg_idx'(paddr[2]))
                zlema_pkg::REG_PERIOD: r_period <= pwdata[zlema_pkg::PERIOD_W-1:0];
                zlema_pkg::REG_ALPHA:  r_alpha  <= pwdata[zlema_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake
    assign out_free   = !r_out_vld || o_out.ready;
    assign s1_go      = r_s1_vld && out_free;
    assign i_in.ready = !r_s1_vld || out_free;
    assign acc        = i_in.valid && i_in.ready;

    // Stage one: lag, warm-up position, delay-line access
    always_comb begin
        lag8 = (r_period == '0) ? '0 : ((r_period - 1'b1) >> 1);
        if (lag8 == '0) begin
            lag = LGW'(1);
        end else if (32'(lag8) > 32'(MAX_LAG)) begin
            lag = LGW'(MAX_LAG);
        end else begin
            lag = LGW'(lag8);
        end

        pos     = i_in.start_of_series ? '0 : r_warm;
        pos_inc = (LGW + 1)'(pos) + 1'b1;
        n_warm  = (32'(pos_inc) > 32'(MAX_LAG)) ? LGW'(MAX_LAG) : pos_inc[LGW-1:0];

        if (pos_inc == (LGW + 1)'(lag)) begin
            n_kind = zlema_pkg::KIND_SEED;
        end else if (pos >= lag) begin
            n_kind = zlema_pkg::KIND_UPDATE;
        end else begin
            n_kind = zlema_pkg::KIND_NONE;
        end

        rsum = (AW + 2)'(r_wp) + (AW + 2)'(MAX_LAG) - (AW + 2)'(lag);
        ridx = (rsum >= (AW + 2)'(MAX_LAG)) ? AW'(rsum - (AW + 2)'(MAX_LAG)) : AW'(rsum);

        wp_inc = (AW + 1)'(r_wp) + 1'b1;
        n_wp   = (wp_inc == (AW + 1)'(MAX_LAG)) ? '0 : wp_inc[AW-1:0];
    end

    zlema_ram #(
        .WIDTH (S),
        .DEPTH (MAX_LAG)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (r_wp),
        .i_wdata (i_in.sample),
        .i_re    (acc),
        .i_raddr (ridx),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_warm   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_wp   <= n_wp;
                r_warm <= n_warm;
            end
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_kind <= n_kind;
            r_s1_c    <= i_in.sample;
        end
    end

    // Stage two: average update
    always_comb begin
        alpha_x = AXW'(r_alpha);
        one_x   = AXW'(1) << F;
        a       = (alpha_x >= one_x) ? F'(one_x - 1'b1) : alpha_x[F-1:0];

        tgt  = ((S + 2)'(r_s1_c) <<< 1) - (S + 2)'($signed(rdata));
        diff = (DW'(tgt) <<< F) - DW'(r_avg);
        dl   = diff[DLW-1:0];
        dh   = diff[DW-1:DLW];
        pl   = PLW'(dl) * PLW'(a);
        ph   = PHW'(dh) * PHW'($signed({1'b0, a}));
        prod = (PW'(ph) <<< DLW) + PW'($signed({1'b0, pl}));
        avg_upd = r_avg + prod[F +: AVW];
        y       = avg_upd[AVW-1:F];

        case (r_s1_kind)
            zlema_pkg::KIND_SEED: begin
                n_avg     = AVW'(r_s1_c) <<< F;
                n_out_avg = r_s1_c;
                n_out_sat = 1'b0;
            end
            zlema_pkg::KIND_UPDATE: begin
                n_avg = avg_upd;
                if ((y[S+1:S-1] == 3'b000) || (y[S+1:S-1] == 3'b111)) begin
                    n_out_avg = y[S-1:0];
                    n_out_sat = 1'b0;
                end else begin
                    n_out_avg = y[S+1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
                    n_out_sat = 1'b1;
                end
            end
            default: begin
                n_avg     = r_avg;
                n_out_avg = r_out_avg;
                n_out_sat = r_out_sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_go) begin
                r_avg     <= n_avg;
                r_out_vld <= (r_s1_kind != zlema_pkg::KIND_NONE);
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && (r_s1_kind != zlema_pkg::KIND_NONE)) begin
            r_out_avg <= n_out_avg;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.average   = r_out_avg;
    assign o_out.saturated = r_out_sat;

endmodule
